// ===== sv/mrq_pkg.sv =====
// mrq_pkg: sizes, operation and status codes, controller states and the
// command/status structs shared by the ready queue modules
// no dependencies
`default_nettype none

package mrq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int LEVEL_COUNT = 5;

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int AGE_W   = IDX_W;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int LEVEL_W = 3;
  localparam int ID_W    = 8;
  localparam int TIME_W  = 32;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 3;
  localparam int POL_W   = 2;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TAKE   = 2'd2;

  // policy codes, anything else serves as round robin
  localparam logic [POL_W-1:0] POL_RR   = 2'd0;
  localparam logic [POL_W-1:0] POL_PRIO = 2'd1;
  localparam logic [POL_W-1:0] POL_FAIR = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_PRIO  = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } ctrl_state_t;

  typedef struct packed {
    logic cfg_wr;  // policy write, clears the queue
    logic load;    // capture the input item, restart the scan
    logic scan;    // examine one slot
    logic apply;   // update the queue and load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;  // the slot under examination is the last one
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/mrq_ctrl.sv =====
// mrq_ctrl: controller state machine for the ready queue
// sequences capture, slot scan and update; owns the result valid flag
// depends on mrq_pkg
`default_nettype none

module mrq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire mrq_pkg::dp_stat_t stat,
  output mrq_pkg::dp_cmd_t      cmd
);
  import mrq_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.apply) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    cfg_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall   = 1'b0;
        cfg_ready  = 1'b1;
        cmd.cfg_wr = cfg_valid;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        if (out_free) begin
          cmd.apply  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/mrq_datapath.sv =====
// mrq_datapath: slot storage, arrival ranks, policy register, one-slot-per-cycle
// selection scan and the result register of the ready queue
// depends on mrq_pkg
`default_nettype none

module mrq_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mrq_pkg::dp_cmd_t              cmd,
  output mrq_pkg::dp_stat_t                  stat,
  input  wire logic [mrq_pkg::POL_W-1:0]     cfg_policy,
  input  wire logic [mrq_pkg::MODE_W-1:0]    mode,
  input  wire logic [mrq_pkg::ID_W-1:0]      task_id,
  input  wire logic [mrq_pkg::LEVEL_W-1:0]   task_priority,
  input  wire logic [mrq_pkg::TIME_W-1:0]    task_cpu_time,
  output logic      [mrq_pkg::ID_W-1:0]      chosen_id,
  output logic      [mrq_pkg::STAT_W-1:0]    status,
  output logic      [mrq_pkg::COUNT_W-1:0]   queued_count
);
  import mrq_pkg::*;

  // queue state
  logic [QUEUE_DEPTH-1:0]              slot_valid;
  logic [QUEUE_DEPTH-1:0][ID_W-1:0]    slot_task;
  logic [QUEUE_DEPTH-1:0][LEVEL_W-1:0] slot_level;
  logic [QUEUE_DEPTH-1:0][TIME_W-1:0]  slot_time;
  logic [QUEUE_DEPTH-1:0][AGE_W-1:0]   slot_age;
  logic [COUNT_W-1:0]                  task_total;
  logic [POL_W-1:0]                    policy;

  // captured item
  logic [MODE_W-1:0]  op_mode;
  logic [ID_W-1:0]    op_id;
  logic [LEVEL_W-1:0] op_prio;
  logic [TIME_W-1:0]  op_time;

  // scan state
  logic [IDX_W-1:0]   idx;
  logic               found;
  logic [IDX_W-1:0]   best_idx;
  logic [ID_W-1:0]    best_task;
  logic [LEVEL_W-1:0] best_level;
  logic [TIME_W-1:0]  best_time;
  logic [AGE_W-1:0]   best_age;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  // current slot under scan
  logic               cur_valid;
  logic [ID_W-1:0]    cur_task;
  logic [LEVEL_W-1:0] cur_level;
  logic [TIME_W-1:0]  cur_time;
  logic [AGE_W-1:0]   cur_age;
  logic               serves_first;
  logic               pick;

  // apply decisions
  logic               add_ok;
  logic               drop_ok;
  logic [STAT_W-1:0]  res_status;
  logic [ID_W-1:0]    res_chosen;
  logic [COUNT_W-1:0] res_count;

  assign cur_valid = slot_valid[idx];
  assign cur_task  = slot_task[idx];
  assign cur_level = slot_level[idx];
  assign cur_time  = slot_time[idx];
  assign cur_age   = slot_age[idx];

  assign stat.scan_last = (idx == IDX_W'(QUEUE_DEPTH - 1));

  // serve order of the current slot against the best so far
  always_comb begin
    case (policy)
      POL_PRIO: serves_first = (cur_level != best_level) ? (cur_level > best_level)
                                                         : (cur_age < best_age);
      POL_FAIR: serves_first = (cur_time != best_time) ? (cur_time < best_time)
                                                       : (cur_age < best_age);
      default:  serves_first = (cur_age > best_age);
    endcase
  end

  always_comb begin
    case (op_mode)
      MODE_REMOVE: pick = cur_valid && (cur_task == op_id) &&
                          (!found || (cur_age > best_age));
      MODE_TAKE:   pick = cur_valid && (!found || serves_first);
      default:     pick = 1'b0;
    endcase
  end

  always_comb begin
    add_ok     = 1'b0;
    drop_ok    = 1'b0;
    res_status = ST_OK;
    res_chosen = '0;
    case (op_mode)
      MODE_ADD: begin
        if (policy == POL_PRIO &&
            {1'b0, op_prio} >= (LEVEL_W + 1)'(LEVEL_COUNT)) begin
          res_status = ST_BAD_PRIO;
        end else if (task_total >= COUNT_W'(QUEUE_DEPTH) || !free_found) begin
          res_status = ST_FULL;
        end else begin
          add_ok = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (found) begin
          drop_ok = 1'b1;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      MODE_TAKE: begin
        if (found) begin
          drop_ok    = 1'b1;
          res_chosen = best_task;
        end else begin
          res_status = ST_EMPTY;
        end
      end
      default: res_status = ST_OK;
    endcase
    if (add_ok) begin
      res_count = task_total + 1'b1;
    end else if (drop_ok) begin
      res_count = task_total - 1'b1;
    end else begin
      res_count = task_total;
    end
  end

  // control-side state: policy, valid bits, fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= POL_RR;
      slot_valid <= '0;
      task_total <= '0;
    end else if (cmd.cfg_wr) begin
      policy     <= cfg_policy;
      slot_valid <= '0;
      task_total <= '0;
    end else if (cmd.apply) begin
      task_total <= res_count;
      if (add_ok) begin
        slot_valid[free_idx] <= 1'b1;
      end else if (drop_ok) begin
        slot_valid[best_idx] <= 1'b0;
      end
    end
  end

  // item capture, scan, result register and slot payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode    <= mode;
      op_id      <= task_id;
      op_prio    <= task_priority;
      op_time    <= task_cpu_time;
      idx        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end
    if (cmd.scan) begin
      idx <= idx + 1'b1;
      if (!free_found && !cur_valid) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
      if (pick) begin
        found      <= 1'b1;
        best_idx   <= idx;
        best_task  <= cur_task;
        best_level <= cur_level;
        best_time  <= cur_time;
        best_age   <= cur_age;
      end
    end
    if (cmd.apply) begin
      chosen_id    <= res_chosen;
      status       <= res_status;
      queued_count <= res_count;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (add_ok && slot_valid[i]) begin
          slot_age[i] <= slot_age[i] + 1'b1;
        end else if (drop_ok && slot_valid[i] && (slot_age[i] > best_age)) begin
          slot_age[i] <= slot_age[i] - 1'b1;
        end
      end
      if (add_ok) begin
        slot_task[free_idx]  <= op_id;
        slot_level[free_idx] <= op_prio;
        slot_time[free_idx]  <= op_time;
        slot_age[free_idx]   <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/multi_policy_ready_queue_top.sv =====
// multi_policy_ready_queue_top: top level of the task ready queue
// joins the controller (mrq_ctrl) and the datapath (mrq_datapath); uses mrq_pkg
//
// usage
//   input channel (in_valid / in_stall): one item is an operation with mode
//     (add, remove by id, take next), task_id, task_priority, task_cpu_time
//   output channel (out_valid / out_stall): one result item per input item,
//     chosen_id, status and queued_count after the operation
//   config channel (cfg_valid / cfg_ready, data on policy): selects round
//     robin, priority levels or least cpu time; every write empties the queue
//   operation: the datapath examines one of the 16 slots per cycle, then
//     updates the queue and registers the result; the update waits while a
//     previous result is stalled, and an item occupies the block until its
//     update is done, so the block does not take a new item before then
//   in_stall is high from the accepting edge until the update cycle is done;
//     the block takes the next item while the previous result still waits
//   a stalled result holds; the update of the next item waits for it
//   reset: queue empty, policy round robin, no result pending; no clearing
//     pass, since the slot valid bits clear at once
`default_nettype none

module multi_policy_ready_queue_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mrq_pkg::POL_W-1:0]     policy,
  // operation items
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mrq_pkg::MODE_W-1:0]    mode,
  input  wire logic [mrq_pkg::ID_W-1:0]      task_id,
  input  wire logic [mrq_pkg::LEVEL_W-1:0]   task_priority,
  input  wire logic [mrq_pkg::TIME_W-1:0]    task_cpu_time,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [mrq_pkg::ID_W-1:0]      chosen_id,
  output logic      [mrq_pkg::STAT_W-1:0]    status,
  output logic      [mrq_pkg::COUNT_W-1:0]   queued_count
);
  import mrq_pkg::*;

  dp_cmd_t  cmd;   // controller to datapath
  dp_stat_t stat;  // datapath to controller

  mrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mrq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_policy    (policy),
    .mode          (mode),
    .task_id       (task_id),
    .task_priority (task_priority),
    .task_cpu_time (task_cpu_time),
    .chosen_id     (chosen_id),
    .status        (status),
    .queued_count  (queued_count)
  );

endmodule

`default_nettype wire

// ===== sv/mrq_checker.sv =====
// mrq_checker: port-level checks of the ready queue, bound to the top level
// depends on mrq_pkg and multi_policy_ready_queue_top
`default_nettype none

module mrq_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [mrq_pkg::ID_W-1:0]      chosen_id,
  input wire logic [mrq_pkg::STAT_W-1:0]    status,
  input wire logic [mrq_pkg::COUNT_W-1:0]   queued_count
);
  import mrq_pkg::*;

  // a waiting result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // the block is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted on back-to-back cycles");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> queued_count <= COUNT_W'(QUEUE_DEPTH))
    else $error("queued count above depth");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> queued_count == '0 && chosen_id == '0)
    else $error("empty result with tasks or an id");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> queued_count == COUNT_W'(QUEUE_DEPTH))
    else $error("full result below depth");

endmodule

bind multi_policy_ready_queue_top mrq_checker u_mrq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .chosen_id    (chosen_id),
  .status       (status),
  .queued_count (queued_count)
);

`default_nettype wire
